FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active, with its own message.
`define PLLF_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same, with a generic message.
`define PLLF_ASSERT(lbl, clk, rst_n, prop) \
    `PLLF_ASSERT_MSG(lbl, clk, rst_n, prop, "pll factor check failed")

`endif

FILE: hw/rtl/pllf_pkg.sv
package pllf_pkg;

    localparam int FRACTION_BITS_DEFAULT = 24;

    localparam int FREQ_W  = 32;
    localparam int RATIO_W = 4;
    localparam int FRAC_W  = 25;

    localparam int RATIO_MIN = 6;
    localparam int RATIO_MAX = 12;

    // Half-up rounding offset on the last decimal digit.
    localparam int DEC_ROUND = 5;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x.
    localparam int          MUL_W         = 32;
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    // Result fields that travel beside the fraction division.
    typedef struct packed {
        logic               half;
        logic [RATIO_W-1:0] ratio;
        logic               oor;
        logic               inv;
    } pllf_side_t;

    typedef struct packed {
        pllf_side_t        side;
        logic [FRAC_W-1:0] frac;
    } pllf_res_t;

endpackage

FILE: hw/rtl/pllf_div_cell.sv
module pllf_div_cell #(
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_quo,
    input  logic [DW-1:0] in_div,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_div
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic          valid_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic [DW-1:0] div_reg;

    // One restoring step: the next dividend bit enters the partial remainder,
    // and the quotient bit takes its place at the low end of the shift word.
    always_comb
    begin
        trial    = {in_rem, in_quo[QW-1]};
        diff     = trial - {1'b0, in_div};
        fits     = (trial >= {1'b0, in_div});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {in_quo[QW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            div_reg <= in_div;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;

endmodule

FILE: hw/rtl/pllf_div_chain.sv
module pllf_div_chain #(
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_quo,
    input  logic [DW-1:0] in_div,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_div
);

    // One cell per quotient bit; element 0 is the chain input.
    logic          v_link   [QW+1];
    logic [DW-1:0] rem_link [QW+1];
    logic [QW-1:0] quo_link [QW+1];
    logic [DW-1:0] div_link [QW+1];

    assign v_link[0]   = in_valid;
    assign rem_link[0] = in_rem;
    assign quo_link[0] = in_quo;
    assign div_link[0] = in_div;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        pllf_div_cell #(
            .DW (DW),
            .QW (QW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_link[i]),
            .in_rem    (rem_link[i]),
            .in_quo    (quo_link[i]),
            .in_div    (div_link[i]),
            .out_valid (v_link[i+1]),
            .out_rem   (rem_link[i+1]),
            .out_quo   (quo_link[i+1]),
            .out_div   (div_link[i+1])
        );
    end

    assign out_valid = v_link[QW];
    assign out_rem   = rem_link[QW];
    assign out_quo   = quo_link[QW];
    assign out_div   = div_link[QW];

endmodule

FILE: hw/rtl/pll_integer_fraction_factor_calc_top.sv
// Fractional-N PLL factor calculator. Each transfer on the req side carries a
// target and a reference frequency; one result transfer follows on the rsp
// side with the prescale flag, the low four bits of the ratio N, the rounded
// fraction K, the range flag and the invalid-reference flag. The block takes
// one request per clock while req_stall is low and passes it through two
// 32-cell restoring divider chains (one bit per cell, by the reference and by
// the halved reference side by side), a select stage, a chain of
// FRACTION_BITS + 4 cells for the fraction, a rounding stage, a reciprocal
// multiply for the divide by ten, and the output register. A skid register
// holds one result while rsp_stall is high; req_stall rises only once that
// register is occupied, and the whole pipeline then holds until it drains.
module pll_integer_fraction_factor_calc_top #(
    parameter int FRACTION_BITS = pllf_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [pllf_pkg::FREQ_W-1:0]         target_frequency,
    input  logic [pllf_pkg::FREQ_W-1:0]         reference_frequency,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic                                prescale_half,
    output logic [pllf_pkg::RATIO_W-1:0]        integer_ratio,
    output logic [pllf_pkg::FRAC_W-1:0]         fraction_value,
    output logic                                ratio_out_of_range,
    output logic                                invalid_reference
);

    localparam int FW      = pllf_pkg::FREQ_W;
    localparam int FQW     = FRACTION_BITS + 4;
    localparam int TEN_W   = FW + 4;
    localparam int PROD_W  = 2 * pllf_pkg::MUL_W;

    logic en;

    // Integer divider chains.
    logic          full_valid;
    logic [FW-1:0] full_rem;
    logic [FW-1:0] full_quo;
    logic [FW-1:0] full_div;
    logic          half_valid;
    logic [FW-1:0] half_rem;
    logic [FW-1:0] half_quo;
    logic [FW-1:0] half_div;

    // Select stage.
    logic                 sel_valid_reg;
    logic                 sel_valid_next;
    logic [FW-1:0]        sel_rem_reg;
    logic [FW-1:0]        sel_rem_next;
    logic [FQW-1:0]       sel_quo_reg;
    logic [FQW-1:0]       sel_quo_next;
    logic [FW-1:0]        sel_div_reg;
    logic [FW-1:0]        sel_div_next;
    pllf_pkg::pllf_side_t sel_side_reg;
    pllf_pkg::pllf_side_t sel_side_next;
    logic [FW-1:0]        pick_rem;
    logic [FW-1:0]        pick_quo;
    logic [TEN_W-1:0]     rem_x10;

    // Fraction chain.
    logic                 frac_valid;
    logic [FQW-1:0]       frac_quo;
    pllf_pkg::pllf_side_t side_pipe_reg [FQW];

    // Rounding and divide by ten.
    logic                      rnd_valid_reg;
    logic [pllf_pkg::MUL_W-1:0] rnd_val_reg;
    logic [pllf_pkg::MUL_W-1:0] rnd_val_next;
    pllf_pkg::pllf_side_t      rnd_side_reg;
    logic                      mul_valid_reg;
    logic [PROD_W-1:0]         mul_prod_reg;
    pllf_pkg::pllf_side_t      mul_side_reg;
    pllf_pkg::pllf_res_t       mul_res;

    // Output register and skid register.
    logic                rsp_valid_reg;
    logic                skid_valid_reg;
    pllf_pkg::pllf_res_t rsp_res_reg;
    pllf_pkg::pllf_res_t skid_res_reg;

    assign en        = !skid_valid_reg;
    assign req_stall = skid_valid_reg;

    pllf_div_chain #(
        .DW (FW),
        .QW (FW)
    ) u_full_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_rem    ('0),
        .in_quo    (target_frequency),
        .in_div    (reference_frequency),
        .out_valid (full_valid),
        .out_rem   (full_rem),
        .out_quo   (full_quo),
        .out_div   (full_div)
    );

    pllf_div_chain #(
        .DW (FW),
        .QW (FW)
    ) u_half_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_rem    ('0),
        .in_quo    (target_frequency),
        .in_div    ({1'b0, reference_frequency[FW-1:1]}),
        .out_valid (half_valid),
        .out_rem   (half_rem),
        .out_quo   (half_quo),
        .out_div   (half_div)
    );

    // Choose the full or halved reference, then set up the fraction division
    // of 10 * rem * 2^FRACTION_BITS by the chosen reference. The partial
    // remainder starts with all but the low four bits of 10 * rem, which is
    // below the reference since 10 * rem < 16 * reference.
    always_comb
    begin
        sel_side_next = '0;
        sel_div_next  = full_div;
        pick_rem      = full_rem;
        pick_quo      = full_quo;
        if (full_div == '0)
        begin
            sel_side_next.inv = 1'b1;
        end
        else if (full_quo < FW'(pllf_pkg::RATIO_MIN))
        begin
            if (half_div == '0)
            begin
                sel_side_next.inv = 1'b1;
            end
            else
            begin
                sel_side_next.half = 1'b1;
                sel_div_next       = half_div;
                pick_rem           = half_rem;
                pick_quo           = half_quo;
            end
        end
        if (!sel_side_next.inv)
        begin
            sel_side_next.ratio = pick_quo[pllf_pkg::RATIO_W-1:0];
            sel_side_next.oor   = (pick_quo < FW'(pllf_pkg::RATIO_MIN)) ||
                                  (pick_quo > FW'(pllf_pkg::RATIO_MAX));
        end
        rem_x10        = ({4'b0, pick_rem} << 3) + ({4'b0, pick_rem} << 1);
        sel_rem_next   = rem_x10[TEN_W-1:4];
        sel_quo_next   = {rem_x10[3:0], {FRACTION_BITS{1'b0}}};
        sel_valid_next = full_valid && half_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sel_valid_reg <= sel_valid_next;
            rnd_valid_reg <= frac_valid;
            mul_valid_reg <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_rem_reg  <= sel_rem_next;
            sel_quo_reg  <= sel_quo_next;
            sel_div_reg  <= sel_div_next;
            sel_side_reg <= sel_side_next;
        end
    end

    // The final remainder and divisor of the fraction chain are not needed.
    pllf_div_chain #(
        .DW (FW),
        .QW (FQW)
    ) u_frac_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sel_valid_reg),
        .in_rem    (sel_rem_reg),
        .in_quo    (sel_quo_reg),
        .in_div    (sel_div_reg),
        .out_valid (frac_valid),
        .out_rem   (),
        .out_quo   (frac_quo),
        .out_div   ()
    );

    // The result flags walk beside the fraction cells.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pipe_reg[0] <= sel_side_reg;
            for (int i = 1; i < FQW; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
            end
        end
    end

    // Rounding half up on the last decimal digit is (q + 5) / 10 for every q.
    always_comb
    begin
        rnd_val_next = pllf_pkg::MUL_W'(frac_quo) +
                       pllf_pkg::MUL_W'(pllf_pkg::DEC_ROUND);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_val_reg  <= rnd_val_next;
            rnd_side_reg <= side_pipe_reg[FQW-1];
            mul_prod_reg <= PROD_W'(rnd_val_reg) * PROD_W'(pllf_pkg::RECIP10);
            mul_side_reg <= rnd_side_reg;
        end
    end

    always_comb
    begin
        mul_res.side = mul_side_reg;
        mul_res.frac = mul_side_reg.inv ? '0 :
                       mul_prod_reg[pllf_pkg::RECIP10_SHIFT +: pllf_pkg::FRAC_W];
    end

    // A result that arrives while the output is held goes to the skid
    // register, which in turn holds the pipeline until it empties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (rsp_valid_reg && rsp_stall)
        begin
            if (mul_valid_reg && en)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            rsp_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid_reg && rsp_stall)
        begin
            if (mul_valid_reg && en)
            begin
                skid_res_reg <= mul_res;
            end
        end
        else if (skid_valid_reg)
        begin
            rsp_res_reg <= skid_res_reg;
        end
        else
        begin
            rsp_res_reg <= mul_res;
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign prescale_half      = rsp_res_reg.side.half;
    assign integer_ratio      = rsp_res_reg.side.ratio;
    assign fraction_value     = rsp_res_reg.frac;
    assign ratio_out_of_range = rsp_res_reg.side.oor;
    assign invalid_reference  = rsp_res_reg.side.inv;

endmodule

FILE: hw/rtl/pllf_checker.sv
`include "assert_macros.svh"

module pllf_checker #(
    parameter int FRACTION_BITS = pllf_pkg::FRACTION_BITS_DEFAULT
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_stall,
    input logic                         rsp_valid,
    input logic                         rsp_stall,
    input logic                         prescale_half,
    input logic [pllf_pkg::RATIO_W-1:0] integer_ratio,
    input logic [pllf_pkg::FRAC_W-1:0]  fraction_value,
    input logic                         ratio_out_of_range,
    input logic                         invalid_reference
);

    localparam int CMP_W = 33;

    logic [CMP_W-1:0] frac_wide;
    logic [CMP_W-1:0] frac_limit;
    logic             in_range_ratio;

    assign frac_wide      = CMP_W'(fraction_value);
    assign frac_limit     = CMP_W'(1) << FRACTION_BITS;
    assign in_range_ratio =
        (integer_ratio >= pllf_pkg::RATIO_W'(pllf_pkg::RATIO_MIN)) &&
        (integer_ratio <= pllf_pkg::RATIO_W'(pllf_pkg::RATIO_MAX));

    // The request side is held back only while a result is already waiting.
    `PLLF_ASSERT_MSG(a_stall_needs_result, clk, rst_n,
        req_stall |-> rsp_valid, "req_stall high with no result waiting")

    // An invalid reference clears every other result field.
    `PLLF_ASSERT_MSG(a_invalid_zero, clk, rst_n,
        rsp_valid && invalid_reference |-> !prescale_half && integer_ratio == '0 &&
        fraction_value == '0 && !ratio_out_of_range, "invalid result not cleared")

    // A ratio inside the range shows as its own four bits.
    `PLLF_ASSERT(a_ratio_in_range, clk, rst_n,
        rsp_valid && !invalid_reference && !ratio_out_of_range |-> in_range_ratio)

    // While a request is also valid, a result's rounded fraction is checked to be at most one whole unit.
    `PLLF_ASSERT(a_frac_bound, clk, rst_n,
        rsp_valid && req_valid |-> frac_wide <= frac_limit)

    // A held result stays valid and keeps its fraction.
    `PLLF_ASSERT_MSG(a_rsp_hold, clk, rst_n,
        rsp_valid && rsp_stall |=> rsp_valid && $stable(fraction_value),
        "held result changed")

endmodule

bind pll_integer_fraction_factor_calc_top pllf_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_pllf_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req_valid),
    .req_stall          (req_stall),
    .rsp_valid          (rsp_valid),
    .rsp_stall          (rsp_stall),
    .prescale_half      (prescale_half),
    .integer_ratio      (integer_ratio),
    .fraction_value     (fraction_value),
    .ratio_out_of_range (ratio_out_of_range),
    .invalid_reference  (invalid_reference)
);

FILE: sim/tb.sv
module tb;

    localparam int FRAC_BITS    = pllf_pkg::FRACTION_BITS_DEFAULT;
    localparam int PIPE_LATENCY = FRAC_BITS + 40;
    localparam int DECIMAL_BASE = 10;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 630;

    typedef struct {
        logic [pllf_pkg::FREQ_W-1:0] tgt;
        logic [pllf_pkg::FREQ_W-1:0] refc;
        pllf_pkg::pllf_res_t         factors;
    } factor_request_t;

    class pll_factor_scoreboard;
        factor_request_t expected_factors[$];
        int              mismatch_count;
        int              result_count;

        function new();
            mismatch_count = 0;
            result_count   = 0;
        endfunction

        // Halves the reference when the ratio falls below the minimum, then
        // scales the remainder into a rounded fixed-point fraction.
        function pllf_pkg::pllf_res_t compute_factors(logic [pllf_pkg::FREQ_W-1:0] tgt,
                                                      logic [pllf_pkg::FREQ_W-1:0] refc);
            pllf_pkg::pllf_res_t         r;
            logic [pllf_pkg::FREQ_W-1:0] divisor;
            logic [pllf_pkg::FREQ_W-1:0] n;
            logic [pllf_pkg::FREQ_W-1:0] rem;
            logic [63:0]                 scaled;
            logic [31:0]                 k;
            logic                        halved;
            r       = '0;
            divisor = refc;
            halved  = 1'b0;
            if (divisor == 0)
            begin
                r.side.inv = 1'b1;
                return r;
            end
            n = tgt / divisor;
            if (n < pllf_pkg::RATIO_MIN)
            begin
                divisor = divisor >> 1;
                halved  = 1'b1;
                if (divisor == 0)
                begin
                    r.side.inv = 1'b1;
                    return r;
                end
                n = tgt / divisor;
            end
            rem    = tgt % divisor;
            scaled = ((64'd1 << FRAC_BITS) * DECIMAL_BASE * {32'd0, rem}) / {32'd0, divisor};
            k      = scaled[31:0];
            if ((k % DECIMAL_BASE) >= pllf_pkg::DEC_ROUND)
                k = k + pllf_pkg::DEC_ROUND;
            k = k / DECIMAL_BASE;
            r.side.half  = halved;
            r.side.ratio = n[pllf_pkg::RATIO_W-1:0];
            r.frac       = k[pllf_pkg::FRAC_W-1:0];
            r.side.oor   = (n < pllf_pkg::RATIO_MIN) || (n > pllf_pkg::RATIO_MAX);
            return r;
        endfunction

        function void note_request(logic [pllf_pkg::FREQ_W-1:0] tgt,
                                   logic [pllf_pkg::FREQ_W-1:0] refc);
            factor_request_t e;
            e.tgt     = tgt;
            e.refc    = refc;
            e.factors = compute_factors(tgt, refc);
            expected_factors.push_back(e);
        endfunction

        function int pending();
            return expected_factors.size();
        endfunction

        task report_mismatch(string what, int got, int want, factor_request_t e);
            $display("result %0d: %s is %0d, expected %0d (target %0d, reference %0d)",
                     result_count, what, got, want, e.tgt, e.refc);
            mismatch_count++;
        endtask

        task check_result(pllf_pkg::pllf_res_t got);
            factor_request_t e;
            if (expected_factors.size() == 0)
            begin
                e.tgt     = '0;
                e.refc    = '0;
                e.factors = '0;
                report_mismatch("unexpected result, fraction", got.frac, 0, e);
                return;
            end
            e = expected_factors.pop_front();
            if (got.side.half !== e.factors.side.half)
                report_mismatch("prescale_half", got.side.half, e.factors.side.half, e);
            if (got.side.ratio !== e.factors.side.ratio)
                report_mismatch("integer_ratio", got.side.ratio, e.factors.side.ratio, e);
            if (got.frac !== e.factors.frac)
                report_mismatch("fraction_value", got.frac, e.factors.frac, e);
            if (got.side.oor !== e.factors.side.oor)
                report_mismatch("ratio_out_of_range", got.side.oor, e.factors.side.oor, e);
            if (got.side.inv !== e.factors.side.inv)
                report_mismatch("invalid_reference", got.side.inv, e.factors.side.inv, e);
            result_count++;
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    logic [pllf_pkg::FREQ_W-1:0]  target_frequency = '0;
    logic [pllf_pkg::FREQ_W-1:0]  reference_frequency = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    logic                         prescale_half;
    logic [pllf_pkg::RATIO_W-1:0] integer_ratio;
    logic [pllf_pkg::FRAC_W-1:0]  fraction_value;
    logic                         ratio_out_of_range;
    logic                         invalid_reference;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int quiet_cycles = 0;

    pll_factor_scoreboard sb = new();

    pll_integer_fraction_factor_calc_top DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .target_frequency   (target_frequency),
        .reference_frequency(reference_frequency),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .prescale_half      (prescale_half),
        .integer_ratio      (integer_ratio),
        .fraction_value     (fraction_value),
        .ratio_out_of_range (ratio_out_of_range),
        .invalid_reference  (invalid_reference)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end

    // Both sides are sampled at the clock edge, before any driver update lands.
    always @(posedge clk)
    begin
        pllf_pkg::pllf_res_t got;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(target_frequency, reference_frequency);
            if (rsp_valid && !rsp_stall)
            begin
                got.side.half  = prescale_half;
                got.side.ratio = integer_ratio;
                got.side.oor   = ratio_out_of_range;
                got.side.inv   = invalid_reference;
                got.frac       = fraction_value;
                sb.check_result(got);
            end
        end
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("pll_integer_fraction_factor_calc_top test failed");
        $finish;
    end

    task send_request(logic [pllf_pkg::FREQ_W-1:0] tgt, logic [pllf_pkg::FREQ_W-1:0] refc);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid           <= 1'b1;
        target_frequency    <= tgt;
        reference_frequency <= refc;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Stop sending and let every outstanding result come back.
    task wait_for_results();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task send_random_requests(int count);
        logic [pllf_pkg::FREQ_W-1:0] tgt;
        logic [pllf_pkg::FREQ_W-1:0] refc;
        logic [63:0]                 prod;
        int                          mult;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // Typical audio PLL setups, ratio around the legal window.
                    refc = $urandom_range(1000, 60_000_000);
                    mult = $urandom_range(3, 14);
                    prod = 64'(refc) * mult + $urandom_range(0, refc - 1);
                    tgt  = prod[31:0];
                end
                5, 6:
                begin
                    tgt  = $urandom;
                    refc = $urandom;
                end
                7:
                begin
                    tgt  = $urandom >> $urandom_range(0, 31);
                    refc = $urandom_range(0, 3);
                end
                8:
                begin
                    tgt  = $urandom >> $urandom_range(0, 31);
                    refc = $urandom >> $urandom_range(0, 31);
                end
                default:
                begin
                    // Land on or just below the edges of the ratio window.
                    refc = $urandom_range(1, 300_000_000);
                    case ($urandom_range(0, 3))
                        0:       mult = pllf_pkg::RATIO_MIN - 1;
                        1:       mult = pllf_pkg::RATIO_MIN;
                        2:       mult = pllf_pkg::RATIO_MAX;
                        default: mult = pllf_pkg::RATIO_MAX + 1;
                    endcase
                    prod = 64'(refc) * mult - $urandom_range(0, 1);
                    tgt  = prod[31:0];
                end
            endcase
            send_request(tgt, refc);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 33;
        receiver_idle_pct = 51;

        send_request(32'd0, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd0);
        send_request(32'd0, 32'd1);
        send_request(32'd5, 32'd1);
        send_request(32'd6, 32'd1);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'd11, 32'd2);
        send_request(32'd6, 32'd2);
        send_request(32'd3, 32'd3);
        send_request(32'd12000, 32'd1000);
        send_request(32'd12999, 32'd1000);
        send_request(32'd13000, 32'd1000);
        send_request(32'd5999, 32'd1000);
        send_request(32'd16999, 32'd1000);
        // Remainder of one less than the reference rounds the fraction up to a full unit.
        send_request(32'hFFFF_FFFF, 32'h2000_0000);
        send_request(32'd98_304_000, 32'd12_000_000);
        send_request(32'd90_316_800, 32'd12_000_000);
        send_request(32'h7FFF_FFFF, 32'h8000_0000);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'h5555_5555, 32'h0AAA_AAAA);
        wait_for_results();

        send_random_requests(PHASE_ITEMS);

        sender_idle_pct   = 51;
        receiver_idle_pct = 33;
        send_random_requests(PHASE_ITEMS);
        wait_for_results();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random_requests(PHASE_ITEMS);
        wait_for_results();

        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("pll_integer_fraction_factor_calc_top test passed");
        else
            $display("pll_integer_fraction_factor_calc_top test failed");
        $finish;
    end
endmodule
